// File: rtl/afu_pkg.sv
`timescale 1ns / 1ps

package afu_pkg;

  // internal fixed point: unsigned, QB fraction bits, 1.0 representable
  localparam int QB = 40;
  localparam int EW = QB + 1;
  localparam int RW = QB + 2;
  localparam int XW = 16;
  localparam int LUT_BITS = 8;
  localparam int LUT_DEPTH = 1 << LUT_BITS;
  // integer part of the exponent at or above 2^EXP_CLAMP_BITS gives e^-a = 0
  localparam int EXP_CLAMP_BITS = 5;

  localparam logic [EW-1:0] QONE = EW'(1) << QB;

  typedef enum logic [1:0] {
    KIND_RELU,
    KIND_SIGMOID,
    KIND_TANH,
    KIND_IDENTITY
  } kind_t;

  typedef enum logic {
    CMD_APPLY,
    CMD_DERIV
  } cmd_t;

  // travels down the pipeline beside the datapath
  typedef struct packed {
    logic            valid;
    cmd_t            cmd;
    kind_t           kind;
    logic            neg;
    logic [XW-1:0]   raw;
    logic [EW-1:0]   aux;
  } tag_t;

  typedef logic [EW-1:0] exp_tab_t [LUT_DEPTH];

  // e^-(j * 2^(LUT_BITS*chunk) / 2^frac_bits) for every chunk code j
  function automatic exp_tab_t exp_table(input int frac_bits, input int chunk);
    exp_tab_t tab;
    real      a;
    for (int j = 0; j < LUT_DEPTH; j++) begin
      a = real'(j) * (2.0 ** (LUT_BITS * chunk - frac_bits));
      tab[j] = EW'(longint'($exp(-a) * (2.0 ** QB)));
    end
    return tab;
  endfunction

endpackage

// File: rtl/afu_mul.sv
`timescale 1ns / 1ps

module afu_mul (
  input  logic                             clk,
  input  logic                             rst_n,
  input  afu_pkg::tag_t                    tag_in,
  input  logic [afu_pkg::EW-1:0]           a,
  input  logic [afu_pkg::EW-1:0]           b,
  output afu_pkg::tag_t                    tag_out,
  output logic [afu_pkg::EW-1:0]           p
);

  localparam int EW = afu_pkg::EW;
  localparam int QB = afu_pkg::QB;
  localparam int LB = (EW + 1) / 2;
  localparam int HB = EW - LB;
  localparam int PW = 2 * EW;
  localparam logic [PW-1:0] HALF = PW'(1) << (QB - 1);

  afu_pkg::tag_t      tag1_r;
  afu_pkg::tag_t      tag2_r;
  logic [EW+LB-1:0]   pl_r;
  logic [EW+HB-1:0]   ph_r;
  logic [EW-1:0]      p_r;
  logic [PW-1:0]      full_w;
  logic [PW-1:0]      rnd_w;

  // stage 1: two partial products on the halves of b
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r.valid <= 1'b0;
    end else begin
      tag1_r <= tag_in;
    end
    pl_r <= a * b[LB-1:0];
    ph_r <= a * b[EW-1:LB];
  end

  assign full_w = {ph_r, {LB{1'b0}}} + {{(PW-EW-LB){1'b0}}, pl_r};
  assign rnd_w  = full_w + HALF;

  // stage 2: sum and round to nearest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r.valid <= 1'b0;
    end else begin
      tag2_r <= tag1_r;
    end
    p_r <= rnd_w[QB +: EW];
  end

  assign tag_out = tag2_r;
  assign p       = p_r;

endmodule

// File: rtl/afu_recip.sv
`timescale 1ns / 1ps

module afu_recip (
  input  logic                             clk,
  input  logic                             rst_n,
  input  afu_pkg::tag_t                    tag_in,
  input  logic [afu_pkg::EW-1:0]           e,
  output afu_pkg::tag_t                    tag_out,
  output logic [afu_pkg::EW-1:0]           r
);

  localparam int EW = afu_pkg::EW;
  localparam int RW = afu_pkg::RW;
  localparam int QB = afu_pkg::QB;
  localparam int NS = EW;

  // floor(2^(2*QB) / (2^QB + e)), one quotient bit per stage
  afu_pkg::tag_t  tag_r [NS];
  logic [RW-1:0]  d_r   [NS];
  logic [RW-1:0]  rem_r [NS];
  logic [EW-1:0]  q_r   [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    afu_pkg::tag_t  tag_s;
    logic [RW-1:0]  d_s;
    logic [RW-1:0]  rem_s;
    logic [EW-1:0]  q_s;
    logic           ge;
    logic [RW-1:0]  diff;

    if (s == 0) begin : g_first
      assign tag_s = tag_in;
      assign d_s   = RW'(afu_pkg::QONE) + RW'(e);
      assign rem_s = RW'(1) << QB;
      assign q_s   = '0;
    end else begin : g_next
      assign tag_s = tag_r[s-1];
      assign d_s   = d_r[s-1];
      assign rem_s = rem_r[s-1];
      assign q_s   = q_r[s-1];
    end

    assign ge   = rem_s >= d_s;
    assign diff = ge ? rem_s - d_s : rem_s;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[s].valid <= 1'b0;
      end else begin
        tag_r[s] <= tag_s;
      end
      d_r[s]   <= d_s;
      rem_r[s] <= {diff[RW-2:0], 1'b0};
      q_r[s]   <= {q_s[EW-2:0], ge};
    end
  end

  assign tag_out = tag_r[NS-1];
  assign r       = q_r[NS-1];

endmodule

// File: rtl/activation_function_unit_core.sv
`timescale 1ns / 1ps

// Activation function unit: relu, sigmoid, tanh or identity, or the derivative
// of the selected function, on signed fixed-point values with FRAC_BITS
// fraction bits (Q4.12 by default).
// Input: drive in_command and in_x with start high; the transaction is taken
// on any edge where busy is low. A new value may be given every cycle.
// Output: out_valid strobes for one cycle with out_y; results come out in
// input order. The receiver cannot hold results off and none is needed.
// Pipeline: a value passes the input register, table lookup, two 2-stage
// multipliers for e^-a, a 41-stage restoring reciprocal, an operand stage,
// a third multiplier and the output register before the strobe.
// Throughput: one transaction per cycle while busy is low; the reciprocal
// pipeline retires one quotient bit per stage, so it never holds the input.
// Configuration: cfg_activation_kind is written when cfg_valid and cfg_ready
// are high; write it only with no transaction in flight.
// Reset: synchronous, active low; empties the pipeline, sets the kind to relu
// and holds busy high for the reset cycle.
module activation_function_unit_core #(
  parameter int FRAC_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic signed [15:0] in_x,
  output logic               out_valid,
  output logic signed [15:0] out_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_activation_kind
);

  localparam int EW = afu_pkg::EW;
  localparam int QB = afu_pkg::QB;
  localparam int XW = afu_pkg::XW;
  localparam int LB = afu_pkg::LUT_BITS;
  localparam int UW = XW + 1;
  localparam int UZ = 3 * LB;

  localparam afu_pkg::exp_tab_t EXP_T0 = afu_pkg::exp_table(FRAC_BITS, 0);
  localparam afu_pkg::exp_tab_t EXP_T1 = afu_pkg::exp_table(FRAC_BITS, 1);
  localparam afu_pkg::exp_tab_t EXP_T2 = afu_pkg::exp_table(FRAC_BITS, 2);
  localparam logic [XW-1:0] ONE_OUT = XW'(1) << FRAC_BITS;
  localparam logic [EW:0]   RND_HALF = (EW + 1)'(1) << (QB - 1 - FRAC_BITS);

  logic               busy_r;
  afu_pkg::kind_t     kind_r;

  // input stage
  afu_pkg::tag_t      in_tag_r;
  logic [UW-1:0]      u_r;
  logic [UW-1:0]      x_ext;
  logic [UW-1:0]      mag;
  logic [UW-1:0]      u_nxt;

  // lookup stage
  afu_pkg::tag_t      lut_tag_r;
  logic [EW-1:0]      t0_r;
  logic [EW-1:0]      t1_r;
  logic [UZ-1:0]      uz;
  logic               ovf;

  afu_pkg::tag_t      m1_tag;
  logic [EW-1:0]      p01;
  afu_pkg::tag_t      m2_tag;
  logic [EW-1:0]      e_w;
  afu_pkg::tag_t      rc_tag;
  logic [EW-1:0]      r_w;

  // operand stage
  afu_pkg::tag_t      op_tag_r;
  afu_pkg::tag_t      op_tag_nxt;
  logic [EW-1:0]      ma_r;
  logic [EW-1:0]      mb_r;
  logic [EW-1:0]      ma_nxt;
  logic [EW-1:0]      mb_nxt;
  logic [EW-1:0]      t_w;

  afu_pkg::tag_t      m3_tag;
  logic [EW-1:0]      p3;

  // output stage
  logic               out_valid_r;
  logic [XW-1:0]      out_y_r;
  logic [EW-1:0]      v_w;
  logic [EW:0]        sum_w;
  logic [XW-1:0]      mag16;
  logic [XW-1:0]      y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      kind_r <= afu_pkg::KIND_RELU;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        kind_r <= afu_pkg::kind_t'(cfg_activation_kind);
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;

  // magnitude, doubled for tanh since it uses e^-2|x|
  assign x_ext = {in_x[XW-1], in_x};
  assign mag   = in_x[XW-1] ? (~x_ext + UW'(1)) : x_ext;
  assign u_nxt = (kind_r == afu_pkg::KIND_TANH) ? {mag[XW-1:0], 1'b0} : mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r.valid <= 1'b0;
    end else begin
      in_tag_r.valid <= start && !busy_r;
    end
    in_tag_r.cmd  <= afu_pkg::cmd_t'(in_command);
    in_tag_r.kind <= kind_r;
    in_tag_r.neg  <= in_x[XW-1];
    in_tag_r.raw  <= in_x;
    in_tag_r.aux  <= '0;
    u_r           <= u_nxt;
  end

  // e^-a as the product of three table entries, one per 8-bit chunk of a
  assign uz  = UZ'(u_r);
  assign ovf = (u_r >> (FRAC_BITS + afu_pkg::EXP_CLAMP_BITS)) != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lut_tag_r.valid <= 1'b0;
    end else begin
      lut_tag_r.valid <= in_tag_r.valid;
    end
    lut_tag_r.cmd  <= in_tag_r.cmd;
    lut_tag_r.kind <= in_tag_r.kind;
    lut_tag_r.neg  <= in_tag_r.neg;
    lut_tag_r.raw  <= in_tag_r.raw;
    lut_tag_r.aux  <= EXP_T2[uz[2*LB +: LB]];
    t0_r           <= ovf ? '0 : EXP_T0[uz[0 +: LB]];
    t1_r           <= EXP_T1[uz[LB +: LB]];
  end

  afu_mul u_mul_exp_lo (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (lut_tag_r),
    .a       (t0_r),
    .b       (t1_r),
    .tag_out (m1_tag),
    .p       (p01)
  );

  afu_mul u_mul_exp_hi (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (m1_tag),
    .a       (p01),
    .b       (m1_tag.aux),
    .tag_out (m2_tag),
    .p       (e_w)
  );

  // r = 1 / (1 + e)
  afu_recip u_recip (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (m2_tag),
    .e       (e_w),
    .tag_out (rc_tag),
    .r       (r_w)
  );

  // tanh = 2r - 1; sigmoid = r, or 1 - r for negative x
  assign t_w = EW'({r_w, 1'b0} - {1'b0, afu_pkg::QONE});

  always_comb begin
    op_tag_nxt     = rc_tag;
    op_tag_nxt.aux = '0;
    ma_nxt         = '0;
    mb_nxt         = '0;
    unique case (rc_tag.kind)
      afu_pkg::KIND_SIGMOID: begin
        ma_nxt         = r_w;
        mb_nxt         = afu_pkg::QONE - r_w;
        op_tag_nxt.aux = rc_tag.neg ? (afu_pkg::QONE - r_w) : r_w;
      end
      afu_pkg::KIND_TANH: begin
        ma_nxt         = t_w;
        mb_nxt         = t_w;
        op_tag_nxt.aux = t_w;
      end
      afu_pkg::KIND_RELU,
      afu_pkg::KIND_IDENTITY: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_tag_r.valid <= 1'b0;
    end else begin
      op_tag_r <= op_tag_nxt;
    end
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
  end

  afu_mul u_mul_deriv (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (op_tag_r),
    .a       (ma_r),
    .b       (mb_r),
    .tag_out (m3_tag),
    .p       (p3)
  );

  always_comb begin
    v_w = m3_tag.aux;
    if (m3_tag.cmd == afu_pkg::CMD_DERIV) begin
      if (m3_tag.kind == afu_pkg::KIND_SIGMOID) begin
        v_w = p3;
      end else if (m3_tag.kind == afu_pkg::KIND_TANH) begin
        v_w = afu_pkg::QONE - p3;
      end
    end
  end

  // round half up on the magnitude, sign applied after
  assign sum_w = {1'b0, v_w} + RND_HALF;
  assign mag16 = XW'(sum_w >> (QB - FRAC_BITS));

  always_comb begin
    y_nxt = mag16;
    unique case (m3_tag.kind)
      afu_pkg::KIND_RELU: begin
        if (m3_tag.neg) begin
          y_nxt = '0;
        end else begin
          y_nxt = (m3_tag.cmd == afu_pkg::CMD_APPLY) ? m3_tag.raw : ONE_OUT;
        end
      end
      afu_pkg::KIND_SIGMOID: begin
        y_nxt = mag16;
      end
      afu_pkg::KIND_TANH: begin
        if ((m3_tag.cmd == afu_pkg::CMD_APPLY) && m3_tag.neg) begin
          y_nxt = XW'(0) - mag16;
        end else begin
          y_nxt = mag16;
        end
      end
      afu_pkg::KIND_IDENTITY: begin
        y_nxt = (m3_tag.cmd == afu_pkg::CMD_APPLY) ? m3_tag.raw : ONE_OUT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= m3_tag.valid;
    end
    out_y_r <= y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;

endmodule

// File: tb/activation_function_unit_core_tb.sv
`timescale 1ns / 1ps

module activation_function_unit_core_tb;
  import afu_pkg::*;

  localparam int FRAC = 12;
  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [15:0] ONE_OUT = 16'd1 << FRAC;

  typedef struct packed {
    kind_t       kind;
    cmd_t        cmd;
    logic [15:0] x;
    logic        typed;
    logic [15:0] y;
  } vec_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_command;
  logic signed [15:0] in_x;
  logic               out_valid;
  logic signed [15:0] out_y;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_activation_kind;

  logic [15:0] expected_y_q [$];
  kind_t       cur_kind;
  int          mismatches = 0;

  vec_t vectors [0:20] = '{
    '{KIND_RELU,     CMD_APPLY, 16'h0000, 1'b1, 16'h0000},
    '{KIND_RELU,     CMD_APPLY, 16'h7FFF, 1'b1, 16'h7FFF},
    '{KIND_RELU,     CMD_APPLY, 16'h8000, 1'b1, 16'h0000},
    '{KIND_RELU,     CMD_APPLY, 16'hFFFF, 1'b1, 16'h0000},
    '{KIND_RELU,     CMD_DERIV, 16'h0000, 1'b1, 16'h1000},
    '{KIND_RELU,     CMD_DERIV, 16'hFFFF, 1'b1, 16'h0000},
    '{KIND_RELU,     CMD_DERIV, 16'h7FFF, 1'b1, 16'h1000},
    '{KIND_IDENTITY, CMD_APPLY, 16'h8000, 1'b1, 16'h8000},
    '{KIND_IDENTITY, CMD_APPLY, 16'h7FFF, 1'b1, 16'h7FFF},
    '{KIND_IDENTITY, CMD_DERIV, 16'h8000, 1'b1, 16'h1000},
    '{KIND_SIGMOID,  CMD_APPLY, 16'h0000, 1'b1, 16'h0800},
    '{KIND_SIGMOID,  CMD_DERIV, 16'h0000, 1'b1, 16'h0400},
    '{KIND_SIGMOID,  CMD_APPLY, 16'h7FFF, 1'b0, 16'h0000},
    '{KIND_SIGMOID,  CMD_APPLY, 16'h8000, 1'b0, 16'h0000},
    '{KIND_SIGMOID,  CMD_DERIV, 16'h8000, 1'b0, 16'h0000},
    '{KIND_TANH,     CMD_APPLY, 16'h0000, 1'b1, 16'h0000},
    '{KIND_TANH,     CMD_DERIV, 16'h0000, 1'b1, 16'h1000},
    '{KIND_TANH,     CMD_APPLY, 16'h7FFF, 1'b0, 16'h0000},
    '{KIND_TANH,     CMD_APPLY, 16'h8000, 1'b0, 16'h0000},
    '{KIND_TANH,     CMD_DERIV, 16'hFFFF, 1'b0, 16'h0000},
    '{KIND_RELU,     CMD_APPLY, 16'h0001, 1'b1, 16'h0001}
  };

  activation_function_unit_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_x                (in_x),
    .out_valid           (out_valid),
    .out_y               (out_y),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_activation_kind (cfg_activation_kind)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Q2.62 arithmetic: products round to nearest, quotients truncate
  function automatic logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62] + {63'd0, p[61]};
  endfunction

  function automatic logic [63:0] q62_div(logic [63:0] n, logic [63:0] d);
    logic [127:0] q;
    q = {2'b00, n, 62'd0} / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] exp_series_q62(logic [63:0] r);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q62_ONE;
    term = Q62_ONE;
    for (int k = 1; k <= 30; k++) begin
      term = q62_mul(term, r) / 64'(k);
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // e^-(m / 2^FRAC)
  function automatic logic [63:0] exp_neg_q62(logic [31:0] m);
    logic [31:0] ip;
    logic [63:0] e;
    logic [63:0] e_one;
    ip = m >> FRAC;
    if (ip >= 64) begin
      return 64'd0;
    end
    e     = exp_series_q62(64'(m & ((32'd1 << FRAC) - 1)) << (62 - FRAC));
    e_one = exp_series_q62(Q62_ONE);
    for (int i = 0; i < ip; i++) begin
      e = q62_mul(e, e_one);
    end
    return e;
  endfunction

  function automatic logic [63:0] q62_to_out(logic [63:0] v);
    return (v + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
  endfunction

  function automatic logic [15:0] activation_y(kind_t kind, cmd_t cmd, logic [15:0] x);
    logic        neg;
    logic [31:0] mag;
    logic [63:0] e;
    logic [63:0] s;
    logic [63:0] t;
    logic [63:0] y;
    neg = x[15];
    mag = neg ? 32'h10000 - {16'd0, x} : {16'd0, x};
    case (kind)
      KIND_RELU: begin
        if (cmd == CMD_APPLY) begin
          y = neg ? 64'd0 : 64'(x);
        end else begin
          y = neg ? 64'd0 : 64'(ONE_OUT);
        end
      end
      KIND_SIGMOID: begin
        e = exp_neg_q62(mag);
        if (cmd == CMD_APPLY) begin
          s = neg ? q62_div(e, Q62_ONE + e) : q62_div(Q62_ONE, Q62_ONE + e);
          y = q62_to_out(s);
        end else begin
          s = q62_div(Q62_ONE, Q62_ONE + e);
          y = q62_to_out(q62_mul(s, Q62_ONE - s));
        end
      end
      KIND_TANH: begin
        e = exp_neg_q62(mag * 2);
        t = q62_div(Q62_ONE - e, Q62_ONE + e);
        if (cmd == CMD_APPLY) begin
          y = q62_to_out(t);
          if (neg) begin
            y = 64'(16'h0 - y[15:0]);
          end
        end else begin
          y = q62_to_out(Q62_ONE - q62_mul(t, t));
        end
      end
      default: begin
        y = (cmd == CMD_APPLY) ? 64'(x) : 64'(ONE_OUT);
      end
    endcase
    return y[15:0];
  endfunction

  task automatic note_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // start is left high so the next transaction can follow back to back
  task automatic send_item(cmd_t cmd, logic [15:0] x, logic [15:0] y);
    @(negedge clk);
    start      <= 1'b1;
    in_command <= cmd;
    in_x       <= x;
    do @(posedge clk); while (busy);
    expected_y_q.push_back(y);
  endtask

  task automatic pause_input(int extra);
    @(negedge clk);
    start <= 1'b0;
    repeat (extra) @(negedge clk);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_y_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_kind(kind_t k);
    drain_results();
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_activation_kind <= k;
    do @(posedge clk); while (!cfg_ready);
    cur_kind = k;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] random_x();
    logic [15:0] corners [5] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
    case ($urandom_range(0, 9))
      0:       return corners[$urandom_range(0, 4)];
      1, 2:    return 16'($urandom_range(0, 8192)) - 16'd4096;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n && out_valid) begin
      if (expected_y_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result y=%h", out_y));
      end else begin
        want = expected_y_q.pop_front();
        if (out_y !== want) begin
          note_mismatch($sformatf("y=%h, want %h", out_y, want));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[activation_function_unit_core] ERROR");
    $finish;
  end

  initial begin
    vec_t        v;
    cmd_t        cmd;
    logic [15:0] x;
    int          idle_pct;
    rst_n               = 1'b0;
    start               = 1'b0;
    in_command          = 1'b0;
    in_x                = '0;
    cfg_valid           = 1'b0;
    cfg_activation_kind = '0;
    cur_kind            = KIND_RELU;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: relu rows rely on the reset kind
    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.kind != cur_kind) begin
        set_kind(v.kind);
      end
      send_item(v.cmd, v.x, v.typed ? v.y : activation_y(cur_kind, v.cmd, v.x));
    end

    for (int p = 0; p < 8; p++) begin
      set_kind(p < 4 ? kind_t'(p) : kind_t'($urandom_range(0, 3)));
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 51;
        default: idle_pct = 13;
      endcase
      for (int i = 0; i < 75; i++) begin
        cmd = cmd_t'($urandom_range(0, 1));
        x   = random_x();
        send_item(cmd, x, activation_y(cur_kind, cmd, x));
        if (p == 5 && i == 37) begin
          drain_results();
        end else if ($urandom_range(1, 100) <= idle_pct) begin
          pause_input($urandom_range(0, 3));
        end
      end
    end

    @(negedge clk);
    start <= 1'b0;
    repeat (2000) begin
      if (expected_y_q.size() != 0) @(posedge clk);
    end
    repeat (60) @(posedge clk);
    foreach (expected_y_q[i]) begin
      note_mismatch($sformatf("missing result, want %h", expected_y_q[i]));
    end
    if (mismatches == 0) begin
      $display("[activation_function_unit_core] OK");
    end else begin
      $display("[activation_function_unit_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/afu_pkg.sv
rtl/afu_mul.sv
rtl/afu_recip.sv
rtl/activation_function_unit_core.sv
tb/activation_function_unit_core_tb.sv
